// File: rtl/core/hak_pkg.sv
package hak_pkg;

  localparam int WORD_W = 32;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam int MIN_CHUNK_SIZE_DEF = 8192;
  localparam int URL_LIMIT_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [WORD_W-1:0] ACK_LEN = 32'd28;
  localparam logic [WORD_W-1:0] ACK_TYPE_WORD = 32'h464B_4341;  // "ACKF" little-endian

  localparam logic [WORD_W-1:0] RECV_LIMIT_RST = 32'd65536;
  localparam logic [WORD_W-1:0] SEND_LIMIT_RST = 32'd65536;
  localparam logic [WORD_W-1:0] MAX_MSG_RST = 32'd2097152;
  localparam logic [WORD_W-1:0] MAX_CHUNKS_RST = 32'd64;

  typedef enum logic [2:0] {
    ST_GOOD      = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_BAD_TYPE  = 3'd2,
    ST_DECODE    = 3'd3,
    ST_URL       = 3'd4,
    ST_NO_RES    = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECV_LIMIT = 2'd0,
    CFG_SEND_LIMIT = 2'd1,
    CFG_MAX_MSG    = 2'd2,
    CFG_MAX_CHUNKS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] ack_byte;
    logic [2:0] status;
    logic       last_out;
    logic       link_open;
  } out_beat_t;

  // one checked hello, handed from the parser to the emitter
  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] peer_receive;
    logic [WORD_W-1:0] peer_send;
    logic [WORD_W-1:0] peer_max_message;
    logic [WORD_W-1:0] peer_max_chunks;
  } job_t;

  // "HELF" type bytes
  function automatic logic [7:0] hello_char(input logic [1:0] lane);
    logic [7:0] c;
    case (lane)
      2'd0:    c = 8'h48;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h4C;
      2'd3:    c = 8'h46;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/hak_front.sv
module hak_front
  import hak_pkg::*;
#(
  parameter int MIN_CHUNK_SIZE = MIN_CHUNK_SIZE_DEF,
  parameter int URL_LIMIT = URL_LIMIT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_beat_t in_data,
  output logic     in_stall,
  output logic     q_push,
  output job_t     q_wdata,
  input  logic     q_full
);

  typedef struct packed {
    logic [WORD_W-1:0] n;
    logic              type_ok;
    logic [WORD_W-1:0] declared;
    logic [WORD_W-1:0] recv;
    logic [WORD_W-1:0] send;
    logic [WORD_W-1:0] max_msg;
    logic [WORD_W-1:0] max_chunks;
    logic [WORD_W-1:0] url_len;
  } chk_t;

  localparam logic [WORD_W-1:0] MinChunk = WORD_W'(MIN_CHUNK_SIZE);
  localparam logic [WORD_W-1:0] UrlLimit = WORD_W'(URL_LIMIT);

  logic [WORD_W-1:0] byte_count_r, byte_count_nxt;
  logic              type_ok_r, type_ok_nxt;
  logic [WORD_W-1:0] declared_r, declared_nxt;
  logic [WORD_W-1:0] recv_r, recv_nxt;
  logic [WORD_W-1:0] send_r, send_nxt;
  logic [WORD_W-1:0] max_msg_r, max_msg_nxt;
  logic [WORD_W-1:0] max_chunks_r, max_chunks_nxt;
  logic [WORD_W-1:0] url_len_r, url_len_nxt;
  logic              chk_valid_r, chk_valid_nxt;
  chk_t              chk_r, chk_nxt;

  logic        accept;
  logic        in_header;
  logic [2:0]  field;
  logic [1:0]  lane;
  status_t     status;

  function automatic logic [WORD_W-1:0] put_byte(input logic [WORD_W-1:0] word,
                                                 input logic [1:0] ln,
                                                 input logic [7:0] b);
    logic [WORD_W-1:0] w;
    w = word;
    case (ln)
      2'd0:    w[7:0] = b;
      2'd1:    w[15:8] = b;
      2'd2:    w[23:16] = b;
      2'd3:    w[31:24] = b;
      default: w = word;
    endcase
    return w;
  endfunction

  assign in_stall  = chk_valid_r & q_full;
  assign accept    = in_valid & ~in_stall;
  assign in_header = (byte_count_r[WORD_W-1:5] == '0);
  assign field     = byte_count_r[4:2];
  assign lane      = byte_count_r[1:0];

  always_comb begin
    byte_count_nxt = byte_count_r;
    type_ok_nxt    = type_ok_r;
    declared_nxt   = declared_r;
    recv_nxt       = recv_r;
    send_nxt       = send_r;
    max_msg_nxt    = max_msg_r;
    max_chunks_nxt = max_chunks_r;
    url_len_nxt    = url_len_r;
    chk_nxt        = chk_r;
    chk_valid_nxt  = q_push ? 1'b0 : chk_valid_r;
    if (accept) begin
      if (in_header) begin
        case (field)
          3'd0: begin
            if (in_data.data_byte != hello_char(lane)) type_ok_nxt = 1'b0;
          end
          3'd1:    declared_nxt   = put_byte(declared_r, lane, in_data.data_byte);
          3'd2:    ;  // protocol version dropped
          3'd3:    recv_nxt       = put_byte(recv_r, lane, in_data.data_byte);
          3'd4:    send_nxt       = put_byte(send_r, lane, in_data.data_byte);
          3'd5:    max_msg_nxt    = put_byte(max_msg_r, lane, in_data.data_byte);
          3'd6:    max_chunks_nxt = put_byte(max_chunks_r, lane, in_data.data_byte);
          3'd7:    url_len_nxt    = put_byte(url_len_r, lane, in_data.data_byte);
          default: ;
        endcase
      end
      if (byte_count_r != '1) byte_count_nxt = byte_count_r + 1'b1;
      if (in_data.last_in) begin
        // snapshot for the check stage, then back to a clean parse
        chk_nxt.n          = byte_count_nxt;
        chk_nxt.type_ok    = type_ok_nxt;
        chk_nxt.declared   = declared_nxt;
        chk_nxt.recv       = recv_nxt;
        chk_nxt.send       = send_nxt;
        chk_nxt.max_msg    = max_msg_nxt;
        chk_nxt.max_chunks = max_chunks_nxt;
        chk_nxt.url_len    = url_len_nxt;
        chk_valid_nxt      = 1'b1;
        byte_count_nxt     = '0;
        type_ok_nxt        = 1'b1;
        declared_nxt       = '0;
        recv_nxt           = '0;
        send_nxt           = '0;
        max_msg_nxt        = '0;
        max_chunks_nxt     = '0;
        url_len_nxt        = '0;
      end
    end
  end

  // checks in priority order
  always_comb begin
    if (chk_r.n < 32'd8) begin
      status = ST_TOO_LARGE;
    end else if (!chk_r.type_ok) begin
      status = ST_BAD_TYPE;
    end else if (!chk_r.declared[WORD_W-1] && (chk_r.declared > chk_r.n)) begin
      status = ST_TOO_LARGE;
    end else if (chk_r.n < 32'd32) begin
      status = ST_DECODE;
    end else if (!chk_r.url_len[WORD_W-1] && (chk_r.url_len != '0)
                 && ((chk_r.n - 32'd32) < chk_r.url_len)) begin
      status = ST_DECODE;
    end else if (!chk_r.url_len[WORD_W-1] && (chk_r.url_len >= UrlLimit)) begin
      status = ST_URL;
    end else if ((chk_r.recv < MinChunk) || (chk_r.send < MinChunk)) begin
      status = ST_NO_RES;
    end else begin
      status = ST_GOOD;
    end
  end

  assign q_push                   = chk_valid_r & ~q_full;
  assign q_wdata.status           = status;
  assign q_wdata.peer_receive     = chk_r.recv;
  assign q_wdata.peer_send        = chk_r.send;
  assign q_wdata.peer_max_message = chk_r.max_msg;
  assign q_wdata.peer_max_chunks  = chk_r.max_chunks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      type_ok_r    <= 1'b1;
      declared_r   <= '0;
      recv_r       <= '0;
      send_r       <= '0;
      max_msg_r    <= '0;
      max_chunks_r <= '0;
      url_len_r    <= '0;
      chk_valid_r  <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      type_ok_r    <= type_ok_nxt;
      declared_r   <= declared_nxt;
      recv_r       <= recv_nxt;
      send_r       <= send_nxt;
      max_msg_r    <= max_msg_nxt;
      max_chunks_r <= max_chunks_nxt;
      url_len_r    <= url_len_nxt;
      chk_valid_r  <= chk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r <= chk_nxt;
  end

endmodule

// File: rtl/core/hak_queue.sv
module hak_queue
  import hak_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output job_t rdata,
  output logic empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  job_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full  = (count_r == DepthC);
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop from empty queue");
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n) count_r <= DepthC)
    else $error("queue count beyond depth");
`endif

endmodule

// File: rtl/core/hak_back.sv
module hak_back
  import hak_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 q_empty,
  input  job_t                 q_rdata,
  output logic                 q_pop,
  output logic                 out_valid,
  output out_beat_t            out_data,
  input  logic                 out_stall
);

  logic [WORD_W-1:0] recv_limit_r, send_limit_r, max_msg_r, max_chunks_r;

  job_t       job_r;
  logic       job_valid_r, job_valid_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_beat_t  out_beat_r, out_beat_nxt;
  logic       link_open_r, link_open_nxt;

  logic              out_free, emit, job_err, job_done;
  logic [WORD_W-1:0] opa, opb, fallback, mn, word;
  logic              use_min, use_fb;
  logic [7:0]        ack_byte;

  assign out_free = ~out_valid_r | ~out_stall;
  assign emit     = job_valid_r & out_free;
  assign job_err  = (job_r.status != ST_GOOD);
  assign job_done = emit & (job_err | (idx_r == 5'(ACK_LEN - 1)));
  assign q_pop    = ~q_empty & (~job_valid_r | job_done);

  // pick the operand pair of the word in flight, then one min
  always_comb begin
    opa      = '0;
    opb      = '0;
    fallback = '0;
    use_min  = 1'b0;
    use_fb   = 1'b0;
    case (idx_r[4:2])
      3'd0: opa = ACK_TYPE_WORD;
      3'd1: opa = ACK_LEN;
      3'd2: opa = '0;
      3'd3: begin
        opa = job_r.peer_send; opb = recv_limit_r; use_min = 1'b1;
      end
      3'd4: begin
        opa = job_r.peer_receive; opb = send_limit_r; use_min = 1'b1;
      end
      3'd5: begin
        opa = job_r.peer_max_message; opb = max_msg_r; use_min = 1'b1;
        fallback = max_msg_r; use_fb = 1'b1;
      end
      3'd6: begin
        opa = job_r.peer_max_chunks; opb = max_chunks_r; use_min = 1'b1;
        fallback = max_chunks_r; use_fb = 1'b1;
      end
      default: opa = '0;
    endcase
    mn = (use_min && (opb < opa)) ? opb : opa;
    word = (use_fb && (mn == '0)) ? fallback : mn;
    case (idx_r[1:0])
      2'd0:    ack_byte = word[7:0];
      2'd1:    ack_byte = word[15:8];
      2'd2:    ack_byte = word[23:16];
      2'd3:    ack_byte = word[31:24];
      default: ack_byte = '0;
    endcase
  end

  always_comb begin
    job_valid_nxt = job_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    link_open_nxt = link_open_r;
    if (out_free) out_valid_nxt = emit;
    if (emit) begin
      if (job_err) begin
        out_beat_nxt.ack_byte  = '0;
        out_beat_nxt.status    = job_r.status;
        out_beat_nxt.last_out  = 1'b1;
        out_beat_nxt.link_open = link_open_r;
      end else begin
        out_beat_nxt.ack_byte  = ack_byte;
        out_beat_nxt.status    = ST_GOOD;
        out_beat_nxt.last_out  = (idx_r == 5'(ACK_LEN - 1));
        out_beat_nxt.link_open = 1'b1;
        link_open_nxt          = 1'b1;
      end
      idx_nxt = idx_r + 1'b1;
    end
    if (job_done) job_valid_nxt = 1'b0;
    if (q_pop) begin
      job_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r  <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      link_open_r  <= 1'b0;
      recv_limit_r <= RECV_LIMIT_RST;
      send_limit_r <= SEND_LIMIT_RST;
      max_msg_r    <= MAX_MSG_RST;
      max_chunks_r <= MAX_CHUNKS_RST;
    end else begin
      job_valid_r <= job_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      link_open_r <= link_open_nxt;
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RECV_LIMIT: recv_limit_r <= cfg_data;
          CFG_SEND_LIMIT: send_limit_r <= cfg_data;
          CFG_MAX_MSG:    max_msg_r    <= cfg_data;
          CFG_MAX_CHUNKS: max_chunks_r <= cfg_data;
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
    if (q_pop) job_r <= q_rdata;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

`ifndef ASSERT_OFF
  a_link_after_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !job_err) |=> link_open_r)
    else $error("link not open after acknowledge beat");
  a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (job_valid_r && (idx_r == '0)))
    else $error("new job did not start at beat zero");
  a_ack_last_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !job_err && (idx_r != 5'(ACK_LEN - 1))) |=> !out_beat_r.last_out)
    else $error("acknowledge ended early");
`endif

endmodule

// File: rtl/core/hello_ack_negotiator_top.sv
// path: last hello byte -> check register -> job queue -> job register -> output register
// throughput: one input byte per cycle; an acknowledge takes 28 output beats, an error one
// the parser only stops when its check stage and the two-entry job queue are both full,
// so a burst of short hellos is set by the 28-beat emitter
// reset: rst_n synchronous active low; clears parse state, queue and link flag,
// reloads the server limits with their defaults
module hello_ack_negotiator_top
  import hak_pkg::*;
#(
  parameter int MIN_CHUNK_SIZE = MIN_CHUNK_SIZE_DEF,
  parameter int URL_LIMIT = URL_LIMIT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // hello byte stream
  input  logic                 in_valid,
  input  in_beat_t             in_data,
  output logic                 in_stall,
  // acknowledge / status beats
  output logic                 out_valid,
  output out_beat_t            out_data,
  input  logic                 out_stall,
  // server limits
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  logic q_push, q_full, q_pop, q_empty;
  job_t q_wdata, q_rdata;

  // register writes never wait
  assign cfg_ready = 1'b1;

  // front: byte capture, field extraction and the ordered hello checks
  hak_front #(
    .MIN_CHUNK_SIZE(MIN_CHUNK_SIZE),
    .URL_LIMIT(URL_LIMIT)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_data(in_data),
    .in_stall(in_stall),
    .q_push(q_push),
    .q_wdata(q_wdata),
    .q_full(q_full)
  );

  // checked hellos waiting for the emitter
  hak_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .wdata(q_wdata),
    .full(q_full),
    .pop(q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  // back: negotiation of limits and the beat sequencer with its output register
  hak_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid & cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .q_empty(q_empty),
    .q_rdata(q_rdata),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_data(out_data),
    .out_stall(out_stall)
  );

endmodule
